// ----- design/cwsc_pkg.sv -----
// package: shared types and constants of the sparse weight compactor
`timescale 1ns / 1ps

package cwsc_pkg;

    localparam int MAX_KERNEL       = 8;
    localparam int MAX_IN_CHANNELS  = 511;
    localparam int MAX_OUT_CHANNELS = 4096;

    localparam int WEIGHT_W = 32;
    localparam int SLOT_W   = 28;
    localparam int POS_W    = 3;
    localparam int KSIZE_W  = 4;
    localparam int IC_W     = 9;
    localparam int OC_CFG_W = 13;
    localparam int OC_CNT_W = 12;
    localparam int CHAN_W   = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IN_CHANNELS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CHANNELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 2'd2;

    typedef enum logic [1:0] {
        KIND_VALUE   = 2'd0,
        KIND_IC_OFFS = 2'd1,
        KIND_OC_OFFS = 2'd2
    } kind_t;

    // effective (clamped) configuration
    typedef struct packed {
        logic [KSIZE_W-1:0]  k;
        logic [IC_W-1:0]     ic;
        logic [OC_CFG_W-1:0] oc;
    } cfg_t;

    // one classified weight: up to three pending results
    typedef struct packed {
        logic                has_val;
        logic                has_ic;
        logic                has_oc;
        logic [WEIGHT_W-1:0] value_bits;
        logic [POS_W-1:0]    row;
        logic [POS_W-1:0]    col;
        logic [SLOT_W-1:0]   val_slot;
        logic [SLOT_W-1:0]   ic_slot;
        logic [SLOT_W-1:0]   ic_offset;
        logic [SLOT_W-1:0]   oc_slot;
        logic [SLOT_W-1:0]   oc_offset;
    } job_t;

    // front to queue
    typedef struct packed {
        logic push;
        job_t job;
    } push_t;

endpackage

// ----- design/cwsc_if.sv -----
// interfaces: weight request channel and sparse entry request channel
`timescale 1ns / 1ps

interface cwsc_in_if;
    logic                            valid;
    logic                            ready;
    logic [cwsc_pkg::WEIGHT_W-1:0]   weight_bits;
    logic                            restart;

    modport source (output valid, output weight_bits, output restart, input ready);
    modport sink   (input valid, input weight_bits, input restart, output ready);
endinterface

interface cwsc_out_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      kind;
    logic [cwsc_pkg::WEIGHT_W-1:0]   value_bits;
    logic [cwsc_pkg::POS_W-1:0]      kernel_row;
    logic [cwsc_pkg::POS_W-1:0]      kernel_col;
    logic [cwsc_pkg::SLOT_W-1:0]     slot;
    logic [cwsc_pkg::SLOT_W-1:0]     offset;
    logic                            last;

    modport source (output valid, output kind, output value_bits, output kernel_row,
                    output kernel_col, output slot, output offset, output last,
                    input ready);
    modport sink   (input valid, input kind, input value_bits, input kernel_row,
                    input kernel_col, input slot, input offset, input last,
                    output ready);
endinterface

// ----- design/cwsc_front.sv -----
// front: accepts weights, tracks position counters, classifies into jobs
`timescale 1ns / 1ps

module cwsc_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  cwsc_pkg::cfg_t     cfg,
    input  logic               q_full,
    output cwsc_pkg::push_t    q_in,
    cwsc_in_if.sink            weights
);

    logic [cwsc_pkg::POS_W-1:0]    row_reg, row_next;
    logic [cwsc_pkg::POS_W-1:0]    col_reg, col_next;
    logic [cwsc_pkg::IC_W-1:0]     icc_reg, icc_next;
    logic [cwsc_pkg::OC_CNT_W-1:0] occ_reg, occ_next;
    logic [cwsc_pkg::SLOT_W-1:0]   tot_reg, tot_next;
    logic [cwsc_pkg::CHAN_W-1:0]   chn_reg, chn_next;

    logic [cwsc_pkg::POS_W-1:0]    rc, cc;
    logic [cwsc_pkg::IC_W-1:0]     icc;
    logic [cwsc_pkg::OC_CNT_W-1:0] occ;
    logic [cwsc_pkg::SLOT_W-1:0]   tot_base, tot_inc;
    logic [cwsc_pkg::CHAN_W-1:0]   chn_base, chn_inc;
    logic                          nz, col_end, row_end, ic_end, oc_end, accept;
    logic [cwsc_pkg::IC_W:0]       ic_p1;
    logic [21:0]                   ic_prod;

    assign accept        = weights.valid && weights.ready;
    assign weights.ready = !q_full;

    always_comb
    begin
        // restart clears counters before this weight is counted
        rc       = weights.restart ? '0 : row_reg;
        cc       = weights.restart ? '0 : col_reg;
        icc      = weights.restart ? '0 : icc_reg;
        occ      = weights.restart ? '0 : occ_reg;
        tot_base = weights.restart ? '0 : tot_reg;
        chn_base = weights.restart ? '0 : chn_reg;

        nz      = (weights.weight_bits[cwsc_pkg::WEIGHT_W-2:0] != '0);
        tot_inc = tot_base + cwsc_pkg::SLOT_W'(nz);
        chn_inc = chn_base + cwsc_pkg::CHAN_W'(nz);

        col_end = ({1'b0, cc} + 4'd1) >= cfg.k;
        row_end = col_end && (({1'b0, rc} + 4'd1) >= cfg.k);
        ic_end  = row_end && (({1'b0, icc} + 10'd1) >= {1'b0, cfg.ic});
        oc_end  = ic_end && (({1'b0, occ} + 13'd1) >= cfg.oc);

        col_next = col_end ? '0 : cc + 3'd1;
        row_next = col_end ? (row_end ? '0 : rc + 3'd1) : rc;
        icc_next = row_end ? (ic_end ? '0 : icc + 9'd1) : icc;
        occ_next = ic_end ? (oc_end ? '0 : occ + 12'd1) : occ;
        chn_next = ic_end ? '0 : chn_inc;
        tot_next = oc_end ? '0 : tot_inc;

        ic_p1   = {1'b0, cfg.ic} + 10'd1;
        ic_prod = 22'(ic_p1) * 22'(occ);

        q_in.push           = accept && (nz || row_end);
        q_in.job.has_val    = nz;
        q_in.job.has_ic     = row_end;
        q_in.job.has_oc     = ic_end;
        q_in.job.value_bits = weights.weight_bits;
        q_in.job.row        = rc;
        q_in.job.col        = cc;
        q_in.job.val_slot   = tot_base;
        q_in.job.ic_slot    = cwsc_pkg::SLOT_W'(ic_prod) + cwsc_pkg::SLOT_W'(icc)
                              + cwsc_pkg::SLOT_W'(1);
        q_in.job.ic_offset  = cwsc_pkg::SLOT_W'(chn_inc);
        q_in.job.oc_slot    = cwsc_pkg::SLOT_W'(occ) + cwsc_pkg::SLOT_W'(1);
        q_in.job.oc_offset  = tot_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            icc_reg <= '0;
            occ_reg <= '0;
            tot_reg <= '0;
            chn_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            icc_reg <= icc_next;
            occ_reg <= occ_next;
            tot_reg <= tot_next;
            chn_reg <= chn_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a nonzero weight always leaves a job behind
    a_nz_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && nz) |-> q_in.push)
        else $error("nonzero weight dropped");

    // output channel end only comes with a channel offset job
    a_oc_has_ic: assert property (@(posedge clk) disable iff (!rst_n)
        (q_in.push && q_in.job.has_oc) |-> q_in.job.has_ic)
        else $error("output channel end without input channel end");
`endif

endmodule

// ----- design/cwsc_queue.sv -----
// queue: short job queue between front and back
`timescale 1ns / 1ps

module cwsc_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  cwsc_pkg::push_t   q_in,
    output logic              q_full,
    output logic              q_valid,
    output cwsc_pkg::job_t    q_job,
    input  logic              q_pop
);

    cwsc_pkg::job_t                mem_reg [cwsc_pkg::QUEUE_DEPTH];
    logic [cwsc_pkg::QPTR_W-1:0]   wr_reg, wr_next;
    logic [cwsc_pkg::QPTR_W-1:0]   rd_reg, rd_next;
    logic [cwsc_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                          do_pop;

    localparam logic [cwsc_pkg::QPTR_W-1:0] PTR_LAST =
        cwsc_pkg::QPTR_W'(cwsc_pkg::QUEUE_DEPTH - 1);
    localparam logic [cwsc_pkg::QCNT_W-1:0] CNT_FULL =
        cwsc_pkg::QCNT_W'(cwsc_pkg::QUEUE_DEPTH);

    assign q_full  = (cnt_reg == CNT_FULL);
    assign q_valid = (cnt_reg != '0);
    assign q_job   = mem_reg[rd_reg];
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        wr_next  = q_in.push ? ((wr_reg == PTR_LAST) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = do_pop ? ((rd_reg == PTR_LAST) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + cwsc_pkg::QCNT_W'(q_in.push) - cwsc_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (q_in.push)
        begin
            mem_reg[wr_reg] <= q_in.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    // fill count stays within depth
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("queue count out of range");
`endif

endmodule

// ----- design/cwsc_back.sv -----
// back: drains jobs, one sparse entry per cycle via an output register unless stalled
`timescale 1ns / 1ps

module cwsc_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  cwsc_pkg::job_t    q_job,
    output logic              q_pop,
    cwsc_out_if.source        entries
);

    cwsc_pkg::job_t                cur_reg;
    logic [2:0]                    pend_reg, pend_next, rem;
    logic                          out_valid_reg, out_valid_next;
    cwsc_pkg::kind_t               kind_reg, kind_next;
    logic [cwsc_pkg::WEIGHT_W-1:0] val_reg, val_next;
    logic [cwsc_pkg::POS_W-1:0]    row_reg, row_next;
    logic [cwsc_pkg::POS_W-1:0]    col_reg, col_next;
    logic [cwsc_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [cwsc_pkg::SLOT_W-1:0]   offs_reg, offs_next;
    logic                          last_reg;
    logic                          busy, adv, emit, done;

    // pend bits: [2] value entry, [1] input channel offset, [0] output channel offset
    always_comb
    begin
        busy = (pend_reg != '0);
        adv  = !out_valid_reg || entries.ready;
        emit = adv && busy;

        kind_next = cwsc_pkg::KIND_OC_OFFS;
        val_next  = '0;
        row_next  = '0;
        col_next  = '0;
        slot_next = cur_reg.oc_slot;
        offs_next = cur_reg.oc_offset;
        rem       = 3'b000;
        if (pend_reg[2])
        begin
            kind_next = cwsc_pkg::KIND_VALUE;
            val_next  = cur_reg.value_bits;
            row_next  = cur_reg.row;
            col_next  = cur_reg.col;
            slot_next = cur_reg.val_slot;
            offs_next = '0;
            rem       = {1'b0, pend_reg[1:0]};
        end
        else if (pend_reg[1])
        begin
            kind_next = cwsc_pkg::KIND_IC_OFFS;
            slot_next = cur_reg.ic_slot;
            offs_next = cur_reg.ic_offset;
            rem       = {2'b00, pend_reg[0]};
        end

        done  = !busy || (emit && (rem == '0));
        q_pop = done && q_valid;

        if (q_pop)
        begin
            pend_next = {q_job.has_val, q_job.has_ic, q_job.has_oc};
        end
        else if (emit)
        begin
            pend_next = rem;
        end
        else
        begin
            pend_next = pend_reg;
        end

        out_valid_next = emit ? 1'b1 : (entries.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_job;
        end
        if (emit)
        begin
            kind_reg <= kind_next;
            val_reg  <= val_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            slot_reg <= slot_next;
            offs_reg <= offs_next;
            last_reg <= (rem == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign entries.valid      = out_valid_reg;
    assign entries.kind       = kind_reg;
    assign entries.value_bits = val_reg;
    assign entries.kernel_row = row_reg;
    assign entries.kernel_col = col_reg;
    assign entries.slot       = slot_reg;
    assign entries.offset     = offs_reg;
    assign entries.last       = last_reg;

`ifndef NO_ASSERTIONS
    // offset entries carry no weight and no position
    a_offs_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != cwsc_pkg::KIND_VALUE)
            |-> (val_reg == '0 && row_reg == '0 && col_reg == '0))
        else $error("offset entry with payload");

    // an output channel offset always closes its request group
    a_oc_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == cwsc_pkg::KIND_OC_OFFS) |-> last_reg)
        else $error("output channel offset not last");
`endif

endmodule

// ----- design/conv_weight_sparse_compactor.sv -----
// top level: dense convolution weight to sparse row compactor
`timescale 1ns / 1ps

// usage
//  - weights: one dense float32 weight per request, in output channel, input
//    channel, row, column order; restart marks the first weight of a tensor
//  - entries: sparse result requests; a nonzero weight gives a value entry,
//    the end of an input channel adds its running channel count, the end of
//    an output channel adds the running total; last marks the final entry
//    caused by one weight
//  - cfg: write port for in_channels, out_channels and kernel_size, written
//    only while the block is idle; values are truncated to width, then clamped
//  - a weight is taken every cycle while the job queue has room; its job is
//    written to the queue, then moved into the back end, and its first entry
//    goes from there into the output register
//  - the back end emits one entry per cycle unless stalled, so a weight with
//    three entries holds it for all three; the 4-deep job queue absorbs bursts
//  - when the receiver stalls, the output register holds, then the queue fills
//    and weights ready drops
//  - reset clears counters, the queue and the output register, and sets the
//    registers to in_channels 1, out_channels 1, kernel_size 3
module conv_weight_sparse_compactor
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [cwsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cwsc_pkg::CFG_DATA_W-1:0]     cfg_data,
    cwsc_in_if.sink                             weights,
    cwsc_out_if.source                          entries
);

    logic [cwsc_pkg::IC_W-1:0]     ic_cfg_reg;
    logic [cwsc_pkg::OC_CFG_W-1:0] oc_cfg_reg;
    logic [cwsc_pkg::KSIZE_W-1:0]  k_cfg_reg;
    cwsc_pkg::cfg_t                cfg;

    cwsc_pkg::push_t               q_in;
    logic                          q_full;
    logic                          q_valid;
    logic                          q_pop;
    cwsc_pkg::job_t                q_job;

    // register writes; an unknown index is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ic_cfg_reg <= cwsc_pkg::IC_W'(1);
            oc_cfg_reg <= cwsc_pkg::OC_CFG_W'(1);
            k_cfg_reg  <= cwsc_pkg::KSIZE_W'(3);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                cwsc_pkg::CFG_IN_CHANNELS:  ic_cfg_reg <= cfg_data[cwsc_pkg::IC_W-1:0];
                cwsc_pkg::CFG_OUT_CHANNELS: oc_cfg_reg <= cfg_data;
                cwsc_pkg::CFG_KERNEL_SIZE:  k_cfg_reg  <= cfg_data[cwsc_pkg::KSIZE_W-1:0];
                default:                    ;
            endcase
        end
    end

    // clamp to the supported ranges
    always_comb
    begin
        cfg.k  = (k_cfg_reg == '0) ? cwsc_pkg::KSIZE_W'(1)
               : ((k_cfg_reg > cwsc_pkg::KSIZE_W'(cwsc_pkg::MAX_KERNEL))
                  ? cwsc_pkg::KSIZE_W'(cwsc_pkg::MAX_KERNEL) : k_cfg_reg);
        // 9-bit register never exceeds the input channel limit
        cfg.ic = (ic_cfg_reg == '0) ? cwsc_pkg::IC_W'(1) : ic_cfg_reg;
        cfg.oc = (oc_cfg_reg == '0) ? cwsc_pkg::OC_CFG_W'(1)
               : ((oc_cfg_reg > cwsc_pkg::OC_CFG_W'(cwsc_pkg::MAX_OUT_CHANNELS))
                  ? cwsc_pkg::OC_CFG_W'(cwsc_pkg::MAX_OUT_CHANNELS) : oc_cfg_reg);
    end

    // front: counters and classification
    cwsc_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_full  (q_full),
        .q_in    (q_in),
        .weights (weights)
    );

    // job queue
    cwsc_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_in    (q_in),
        .q_full  (q_full),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_pop   (q_pop)
    );

    // back: entry sequencing and output register
    cwsc_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_pop   (q_pop),
        .entries (entries)
    );

endmodule
